// ----- sv/dmtp_pkg.sv -----
// ----------------------------------------------------------------------------
// dmtp_pkg
// Shared types, constants and helpers for the DHCP message type parser.
// ----------------------------------------------------------------------------
package dmtp_pkg;

  localparam int MaxLenDefault = 1024;
  localparam int PosW          = 11;
  localparam int ByteW         = 8;
  localparam int StatusW       = 3;
  localparam int OutDataW      = 16;

  localparam logic [PosW-1:0]  PosSat       = 11'd2047;
  localparam logic [PosW-1:0]  CookieFirst  = 11'd236;
  localparam logic [PosW-1:0]  CookieLast   = 11'd239;
  localparam logic [PosW-1:0]  OptionsStart = 11'd240;
  // Packet shorter than 244 bytes: last offset below 243
  localparam logic [PosW-1:0]  ShortLimit   = 11'd243;

  localparam logic [ByteW-1:0] OptPad       = 8'd0;
  localparam logic [ByteW-1:0] OptEnd       = 8'd255;
  localparam logic [ByteW-1:0] OptMsgType   = 8'd53;
  localparam logic [ByteW-1:0] LenOne       = 8'd1;

  typedef enum logic [2:0] {
    PH_WAIT,
    PH_CODE,
    PH_LENGTH,
    PH_SKIP,
    PH_CAPTURE,
    PH_DONE
  } phase_t;

  typedef enum logic [StatusW-1:0] {
    ST_FOUND     = 3'd0,
    ST_SHORT     = 3'd1,
    ST_BAD_COOK  = 3'd2,
    ST_NOT_FOUND = 3'd3,
    ST_TOO_LONG  = 3'd4
  } status_t;

  typedef struct packed {
    logic             valid;
    logic [ByteW-1:0] data;
    logic             last;
  } step_t;

  typedef struct packed {
    logic             valid;
    logic [ByteW-1:0] mtype;
    status_t          status;
  } res_t;

  // Magic cookie byte for offsets 236..239; 236 is a multiple of four
  function automatic logic [ByteW-1:0] cookie_byte(input logic [1:0] idx);
    logic [ByteW-1:0] b;
    case (idx)
      2'd0:    b = 8'h63;
      2'd1:    b = 8'h82;
      2'd2:    b = 8'h53;
      2'd3:    b = 8'h63;
      default: b = 8'h63;
    endcase
    return b;
  endfunction

endpackage

// ----- sv/dhcp_message_type_parser_top.sv -----
// ----------------------------------------------------------------------------
// dhcp_message_type_parser_top
// Byte-stream DHCP parser reporting the message type option of each packet.
// ----------------------------------------------------------------------------
// Feed a BOOTP/DHCP packet one byte per item from offset zero, with tlast on
// its final byte. The block checks the magic cookie at offsets 236 to 239,
// walks the options from offset 240 and captures the first message type
// option (code 53, length 1). For each packet it returns exactly one result
// item, on the last byte: the type in bits 7:0 and a status in bits 10:8
// (0 found, 1 shorter than 244 bytes, 2 bad cookie, 3 not found, 4 longer
// than MAX_LEN). The type reads zero unless the status is found. One byte is
// taken every clock cycle while input is not stalled; the per-byte walk
// update is combinational logic between the input register and the state
// registers, and a result is formed from the last byte in the input register
// and then held in the output register. The output register decouples the
// two sides, so bytes keep flowing while a result waits to be taken; only a
// second result blocked behind an untaken one stalls input.
module dhcp_message_type_parser_top #(
  parameter int MAX_LEN = dmtp_pkg::MaxLenDefault
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_tvalid,
  output logic                          in_tready,
  input  logic [dmtp_pkg::ByteW-1:0]    in_tdata,   // [7:0] data_byte
  input  logic                          in_tlast,   // last_byte
  output logic                          out_tvalid,
  input  logic                          out_tready,
  output logic [dmtp_pkg::OutDataW-1:0] out_tdata   // [7:0] message_type,
                                                    // [10:8] parse_status
);

  logic                       in_vld_r;
  logic [dmtp_pkg::ByteW-1:0] in_data_r;
  logic                       in_last_r;
  logic                       out_free;
  logic                       consume;
  dmtp_pkg::step_t            step;
  dmtp_pkg::res_t             res;

  // Advance the held byte unless it ends a packet and the result slot is full
  assign consume   = in_vld_r && (!in_last_r || out_free);
  assign in_tready = !in_vld_r || consume;

  assign step.valid = consume;
  assign step.data  = in_data_r;
  assign step.last  = in_last_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_vld_r <= 1'b0;
    end else if (in_tready) begin
      in_vld_r <= in_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_tready && in_tvalid) begin
      in_data_r <= in_tdata;
      in_last_r <= in_tlast;
    end
  end

  dmtp_walk #(
    .MAX_LEN (MAX_LEN)
  ) u_walk (
    .clk   (clk),
    .rst_n (rst_n),
    .step  (step),
    .res   (res)
  );

  dmtp_oreg u_oreg (
    .clk        (clk),
    .rst_n      (rst_n),
    .res        (res),
    .free       (out_free),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata)
  );

endmodule

// ----- sv/dmtp_walk.sv -----
// ----------------------------------------------------------------------------
// dmtp_walk
// Per-byte position, cookie and option walk state; forms the result item.
// ----------------------------------------------------------------------------
module dmtp_walk #(
  parameter int MAX_LEN = dmtp_pkg::MaxLenDefault
) (
  input  logic             clk,
  input  logic             rst_n,
  input  dmtp_pkg::step_t  step,
  output dmtp_pkg::res_t   res
);

  localparam logic [dmtp_pkg::PosW-1:0] MaxLenW = dmtp_pkg::PosW'(MAX_LEN);

  logic [dmtp_pkg::PosW-1:0]  pos_r, pos_nxt;
  logic                       cookie_good_r, cookie_good_nxt;
  dmtp_pkg::phase_t           phase_r, phase_nxt;
  logic [dmtp_pkg::ByteW-1:0] skip_r, skip_nxt;
  logic                       is_type_r, is_type_nxt;
  logic                       found_r, found_nxt;
  logic [dmtp_pkg::ByteW-1:0] value_r, value_nxt;

  dmtp_pkg::phase_t           ph_in;
  logic [dmtp_pkg::ByteW-1:0] skip_dec;
  logic [dmtp_pkg::ByteW-1:0] b;

  always_comb begin
    b               = step.data;
    pos_nxt         = pos_r;
    cookie_good_nxt = cookie_good_r;
    phase_nxt       = phase_r;
    skip_nxt        = skip_r;
    is_type_nxt     = is_type_r;
    found_nxt       = found_r;
    value_nxt       = value_r;
    skip_dec        = skip_r - 8'd1;
    res.valid       = 1'b0;
    res.mtype       = '0;
    res.status      = dmtp_pkg::ST_NOT_FOUND;

    if (pos_r >= dmtp_pkg::CookieFirst && pos_r <= dmtp_pkg::CookieLast &&
        b != dmtp_pkg::cookie_byte(pos_r[1:0])) begin
      cookie_good_nxt = 1'b0;
    end

    ph_in = phase_r;
    if (phase_r == dmtp_pkg::PH_WAIT && pos_r == dmtp_pkg::OptionsStart) begin
      ph_in = dmtp_pkg::PH_CODE;
    end
    phase_nxt = ph_in;

    if (pos_r < dmtp_pkg::PosSat) begin
      case (ph_in)
        dmtp_pkg::PH_CODE: begin
          if (b == dmtp_pkg::OptEnd) begin
            phase_nxt = dmtp_pkg::PH_DONE;
          end else if (b != dmtp_pkg::OptPad) begin
            is_type_nxt = (b == dmtp_pkg::OptMsgType);
            phase_nxt   = dmtp_pkg::PH_LENGTH;
          end
        end
        dmtp_pkg::PH_LENGTH: begin
          if (is_type_r && b == dmtp_pkg::LenOne) begin
            phase_nxt = dmtp_pkg::PH_CAPTURE;
          end else if (b == dmtp_pkg::OptPad) begin
            phase_nxt = dmtp_pkg::PH_CODE;
          end else begin
            skip_nxt  = b;
            phase_nxt = dmtp_pkg::PH_SKIP;
          end
        end
        dmtp_pkg::PH_SKIP: begin
          skip_nxt = skip_dec;
          if (skip_dec == '0) begin
            phase_nxt = dmtp_pkg::PH_CODE;
          end
        end
        dmtp_pkg::PH_CAPTURE: begin
          value_nxt = b;
          found_nxt = 1'b1;
          phase_nxt = dmtp_pkg::PH_DONE;
        end
        default: begin
        end
      endcase
    end

    if (pos_r < dmtp_pkg::PosSat) begin
      pos_nxt = pos_r + 11'd1;
    end

    if (step.last) begin
      res.valid = step.valid;
      if (pos_r >= dmtp_pkg::PosSat || pos_r >= MaxLenW) begin
        res.status = dmtp_pkg::ST_TOO_LONG;
      end else if (pos_r < dmtp_pkg::ShortLimit) begin
        res.status = dmtp_pkg::ST_SHORT;
      end else if (!cookie_good_nxt) begin
        res.status = dmtp_pkg::ST_BAD_COOK;
      end else if (found_nxt) begin
        res.status = dmtp_pkg::ST_FOUND;
        res.mtype  = value_nxt;
      end else begin
        res.status = dmtp_pkg::ST_NOT_FOUND;
      end
      // Packet over: back to the reset values
      pos_nxt         = '0;
      cookie_good_nxt = 1'b1;
      phase_nxt       = dmtp_pkg::PH_WAIT;
      skip_nxt        = '0;
      is_type_nxt     = 1'b0;
      found_nxt       = 1'b0;
      value_nxt       = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pos_r         <= '0;
      cookie_good_r <= 1'b1;
      phase_r       <= dmtp_pkg::PH_WAIT;
      skip_r        <= '0;
      is_type_r     <= 1'b0;
      found_r       <= 1'b0;
      value_r       <= '0;
    end else if (step.valid) begin
      pos_r         <= pos_nxt;
      cookie_good_r <= cookie_good_nxt;
      phase_r       <= phase_nxt;
      skip_r        <= skip_nxt;
      is_type_r     <= is_type_nxt;
      found_r       <= found_nxt;
      value_r       <= value_nxt;
    end
  end

endmodule

// ----- sv/dmtp_oreg.sv -----
// ----------------------------------------------------------------------------
// dmtp_oreg
// Result register driving the master-side stream.
// ----------------------------------------------------------------------------
module dmtp_oreg (
  input  logic                            clk,
  input  logic                            rst_n,
  input  dmtp_pkg::res_t                  res,
  output logic                            free,
  output logic                            out_tvalid,
  input  logic                            out_tready,
  output logic [dmtp_pkg::OutDataW-1:0]   out_tdata
);

  logic                       vld_r;
  logic [dmtp_pkg::ByteW-1:0] mtype_r;
  dmtp_pkg::status_t          status_r;

  assign free       = !vld_r || out_tready;
  assign out_tvalid = vld_r;
  assign out_tdata  = {5'd0, status_r, mtype_r};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= 1'b0;
    end else if (free) begin
      vld_r <= res.valid;
    end
  end

  // Hold the result until taken
  always_ff @(posedge clk) begin
    if (free && res.valid) begin
      mtype_r  <= res.mtype;
      status_r <= res.status;
    end
  end

endmodule

// ----- verif/dhcp_message_type_checker.sv -----
// ----------------------------------------------------------------------------
// dhcp_message_type_checker
// Watches both streams of the DHCP message type parser, predicts every
// result item from the accepted bytes and compares it with what comes out.
// ----------------------------------------------------------------------------
module dhcp_message_type_checker #(
  parameter int MAX_LEN = dmtp_pkg::MaxLenDefault
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  input  logic        in_tready,
  input  logic [7:0]  in_tdata,    // [7:0] data_byte
  input  logic        in_tlast,    // last_byte
  input  logic        out_tvalid,
  input  logic        out_tready,
  input  logic [15:0] out_tdata,   // [7:0] message_type, [10:8] parse_status
  output int          fail_count,
  output int          outstanding
);
  import dmtp_pkg::*;

  localparam logic [31:0] CookieWord = 32'h6353_8263;

  typedef struct packed {
    logic [ByteW-1:0] msg_type;
    status_t          status;
  } parse_result_t;

  parse_result_t    pending_results [$];

  logic [PosW-1:0]  offset;
  logic             cookie_ok;
  phase_t           walk;
  logic [ByteW-1:0] skip_left;
  logic             code_is_type;
  logic             type_seen;
  logic [ByteW-1:0] type_value;

  task automatic clear_parser();
    offset       = '0;
    cookie_ok    = 1'b1;
    walk         = PH_WAIT;
    skip_left    = '0;
    code_is_type = 1'b0;
    type_seen    = 1'b0;
    type_value   = '0;
  endtask

  initial fail_count = 0;

  always @(posedge clk) begin : monitor
    parse_result_t    want;
    logic [PosW-1:0]  pos;
    logic [PosW-1:0]  cookie_off;
    logic [ByteW-1:0] b;
    logic [ByteW-1:0] got_type;
    logic [2:0]       got_status;
    int               pkt_len;
    if (!rst_n) begin
      clear_parser();
      pending_results.delete();
    end else begin
      if (in_tvalid && in_tready) begin
        b   = in_tdata;
        pos = offset;
        if (pos >= CookieFirst && pos <= CookieLast) begin
          cookie_off = pos - CookieFirst;
          if (b != CookieWord[8*cookie_off[1:0] +: 8]) cookie_ok = 1'b0;
        end
        if (walk == PH_WAIT && pos == OptionsStart) walk = PH_CODE;
        // Once the counter saturates the walk is frozen
        if (pos < PosSat) begin
          case (walk)
            PH_CODE: begin
              if (b == OptEnd) begin
                walk = PH_DONE;
              end else if (b != OptPad) begin
                code_is_type = (b == OptMsgType);
                walk         = PH_LENGTH;
              end
            end
            PH_LENGTH: begin
              if (code_is_type && b == LenOne) begin
                walk = PH_CAPTURE;
              end else if (b == 8'd0) begin
                walk = PH_CODE;
              end else begin
                skip_left = b;
                walk      = PH_SKIP;
              end
            end
            PH_SKIP: begin
              skip_left = skip_left - 8'd1;
              if (skip_left == 8'd0) walk = PH_CODE;
            end
            PH_CAPTURE: begin
              type_value = b;
              type_seen  = 1'b1;
              walk       = PH_DONE;
            end
            default: ;
          endcase
        end
        if (!in_tlast) begin
          if (offset < PosSat) offset = offset + 1'b1;
        end else begin
          pkt_len       = int'(pos) + 1;
          want.msg_type = '0;
          if (pos >= PosSat || pkt_len > MAX_LEN) begin
            want.status = ST_TOO_LONG;
          end else if (pkt_len < 244) begin
            want.status = ST_SHORT;
          end else if (!cookie_ok) begin
            want.status = ST_BAD_COOK;
          end else if (type_seen) begin
            want.status   = ST_FOUND;
            want.msg_type = type_value;
          end else begin
            want.status = ST_NOT_FOUND;
          end
          pending_results.push_back(want);
          clear_parser();
        end
      end

      if (out_tvalid && out_tready) begin
        got_type   = out_tdata[7:0];
        got_status = out_tdata[10:8];
        if (pending_results.size() == 0) begin
          $display("%0t: result with none pending: expected nothing, got type %0d status %0d",
                   $time, got_type, got_status);
          fail_count++;
        end else begin
          want = pending_results.pop_front();
          if (got_type != want.msg_type) begin
            $display("%0t: message type mismatch: expected %0d, got %0d",
                     $time, want.msg_type, got_type);
            fail_count++;
          end
          if (got_status != want.status) begin
            $display("%0t: parse status mismatch: expected %0d, got %0d",
                     $time, want.status, got_status);
            fail_count++;
          end
          if (out_tdata[15:11] != 5'd0) begin
            $display("%0t: padding bits mismatch: expected 0, got %0d",
                     $time, out_tdata[15:11]);
            fail_count++;
          end
        end
      end
    end
    outstanding = pending_results.size();
  end

endmodule

// ----- verif/tb_dhcp_message_type_parser_top.sv -----
// ----------------------------------------------------------------------------
// tb_dhcp_message_type_parser_top
// Packet stimulus and verdict for the DHCP message type parser.
// ----------------------------------------------------------------------------
// Sends whole packets byte by byte: a directed set covering each status, the
// cookie checks, option walk corner cases, the length limit and counter
// saturation, then random packets, mostly well formed with random options.
// A separate checker predicts and compares every result item.
// ----------------------------------------------------------------------------
module tb_dhcp_message_type_parser_top;
  import dmtp_pkg::*;

  localparam int          MaxLen     = dmtp_pkg::MaxLenDefault;
  localparam int          StallLimit = 5000;
  localparam int          TailCycles = 10;
  localparam logic [31:0] CookieWord = 32'h6353_8263;

  logic        clk;
  logic        rst_n;
  logic        in_tvalid;
  logic        in_tready;
  logic [7:0]  in_tdata;    // [7:0] data_byte
  logic        in_tlast;    // last_byte
  logic        out_tvalid;
  logic        out_tready;
  logic [15:0] out_tdata;   // [7:0] message_type, [10:8] parse_status

  int          fail_count;
  int          outstanding;
  int          stall_cycles;
  bit          calm;        // high: neither side idles
  logic [7:0]  pkt_bytes [$];

  dhcp_message_type_parser_top #(.MAX_LEN(MaxLen)) dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tlast   (in_tlast),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata)
  );

  dhcp_message_type_checker #(.MAX_LEN(MaxLen)) u_checker (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_tvalid   (in_tvalid),
    .in_tready   (in_tready),
    .in_tdata    (in_tdata),
    .in_tlast    (in_tlast),
    .out_tvalid  (out_tvalid),
    .out_tready  (out_tready),
    .out_tdata   (out_tdata),
    .fail_count  (fail_count),
    .outstanding (outstanding)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Receiver: stall about a quarter of the cycles unless in a calm stretch
  always @(negedge clk) begin
    out_tready <= calm || ($urandom_range(0, 99) >= 25);
  end

  // Watchdog: give up when nothing moves on either channel for too long
  always @(posedge clk) begin
    if (!rst_n) begin
      stall_cycles <= 0;
    end else if ((in_tvalid && in_tready) || (out_tvalid && out_tready)) begin
      stall_cycles <= 0;
    end else begin
      stall_cycles <= stall_cycles + 1;
      if (stall_cycles >= StallLimit) begin
        $display("CHECK FAILED");
        $finish;
      end
    end
  end

  // Start a packet: random BOOTP header, then the cookie, one byte spoilt
  // at bad_idx when cookie_ok is low
  task automatic start_header(input bit cookie_ok, input int bad_idx);
    logic [7:0] cb;
    pkt_bytes.delete();
    repeat (236) pkt_bytes.push_back(8'($urandom_range(0, 255)));
    for (int i = 0; i < 4; i++) begin
      cb = CookieWord[8*i +: 8];
      if (!cookie_ok && i == bad_idx) cb = cb ^ 8'($urandom_range(1, 255));
      pkt_bytes.push_back(cb);
    end
  endtask

  // Pad with random bytes or cut back to exactly len bytes
  task automatic fit_length(input int len);
    while (pkt_bytes.size() < len) pkt_bytes.push_back(8'($urandom_range(0, 255)));
    while (pkt_bytes.size() > len) void'(pkt_bytes.pop_back());
  endtask

  // Append a random option list up to len bytes; options may be cut off
  task automatic fill_random_options(input int len);
    int kind;
    int n;
    while (pkt_bytes.size() < len) begin
      kind = $urandom_range(0, 99);
      if (kind < 10) begin
        pkt_bytes.push_back(OptPad);
      end else if (kind < 16) begin
        pkt_bytes.push_back(OptEnd);
      end else if (kind < 45) begin
        pkt_bytes.push_back(OptMsgType);
        pkt_bytes.push_back(LenOne);
        pkt_bytes.push_back(($urandom_range(0, 3) == 0) ? 8'd0 : 8'($urandom_range(0, 255)));
      end else begin
        pkt_bytes.push_back((kind < 52) ? OptMsgType : 8'($urandom_range(1, 254)));
        n = ($urandom_range(0, 19) == 0) ? $urandom_range(13, 255) : $urandom_range(0, 12);
        pkt_bytes.push_back(8'(n));
        repeat (n) pkt_bytes.push_back(8'($urandom_range(0, 255)));
      end
    end
    fit_length(len);
  endtask

  // Drive the packet, tlast on its final byte; called and left at a falling edge
  task automatic send_packet();
    for (int i = 0; i < pkt_bytes.size(); i++) begin
      while (!calm && $urandom_range(0, 99) < 25) begin
        in_tvalid <= 1'b0;
        @(negedge clk);
      end
      in_tvalid <= 1'b1;
      in_tdata  <= pkt_bytes[i];
      in_tlast  <= (i == pkt_bytes.size() - 1);
      do @(posedge clk); while (!in_tready);
      @(negedge clk);
    end
  endtask

  // Hold the sender off until every expected result item has come out
  task automatic drain_results();
    in_tvalid <= 1'b0;
    @(negedge clk);
    while (outstanding != 0) @(negedge clk);
  endtask

  initial begin : stimulus
    int kind;
    int pkt_idx;
    int random_bytes;
    rst_n      = 1'b0;
    in_tvalid  = 1'b0;
    in_tdata   = 8'd0;
    in_tlast   = 1'b0;
    out_tready = 1'b0;
    calm       = 1'b0;
    repeat (4) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // --- directed packets ---
    // Single byte: too short
    pkt_bytes.delete();
    pkt_bytes.push_back(8'h00);
    send_packet();

    // One byte under the minimum, with a valid type option: short wins
    start_header(1'b1, 0);
    pkt_bytes.push_back(OptMsgType);
    pkt_bytes.push_back(LenOne);
    pkt_bytes.push_back(8'h07);
    fit_length(243);
    send_packet();

    // Minimum length with the type found
    start_header(1'b1, 0);
    pkt_bytes.push_back(OptMsgType);
    pkt_bytes.push_back(LenOne);
    pkt_bytes.push_back(8'h35);
    pkt_bytes.push_back(OptEnd);
    send_packet();

    // Pad bytes, then a type option holding zero: still found
    start_header(1'b1, 0);
    pkt_bytes.push_back(OptPad);
    pkt_bytes.push_back(OptPad);
    pkt_bytes.push_back(OptMsgType);
    pkt_bytes.push_back(LenOne);
    pkt_bytes.push_back(8'h00);
    fit_length(260);
    send_packet();

    // Spoil each cookie byte in turn
    for (int i = 0; i < 4; i++) begin
      start_header(1'b0, i);
      pkt_bytes.push_back(OptMsgType);
      pkt_bytes.push_back(LenOne);
      pkt_bytes.push_back(8'h05);
      fit_length(250);
      send_packet();
    end

    // End option first: the later type option is ignored
    start_header(1'b1, 0);
    pkt_bytes.push_back(OptEnd);
    pkt_bytes.push_back(OptMsgType);
    pkt_bytes.push_back(LenOne);
    pkt_bytes.push_back(8'h05);
    fit_length(250);
    send_packet();

    // Type option cut off by the last byte: not found
    start_header(1'b1, 0);
    pkt_bytes.push_back(OptPad);
    pkt_bytes.push_back(OptPad);
    pkt_bytes.push_back(OptMsgType);
    pkt_bytes.push_back(LenOne);
    send_packet();

    drain_results();

    // Type option of length two skipped, empty option, then the real one
    start_header(1'b1, 0);
    pkt_bytes.push_back(OptMsgType);
    pkt_bytes.push_back(8'd2);
    pkt_bytes.push_back(8'hAA);
    pkt_bytes.push_back(8'hBB);
    pkt_bytes.push_back(8'd7);
    pkt_bytes.push_back(8'd0);
    pkt_bytes.push_back(OptMsgType);
    pkt_bytes.push_back(LenOne);
    pkt_bytes.push_back(8'h09);
    fit_length(260);
    send_packet();

    // First capture sticks; value at the top of its range
    start_header(1'b1, 0);
    pkt_bytes.push_back(OptMsgType);
    pkt_bytes.push_back(LenOne);
    pkt_bytes.push_back(8'hFF);
    pkt_bytes.push_back(OptMsgType);
    pkt_bytes.push_back(LenOne);
    pkt_bytes.push_back(8'h04);
    fit_length(255);
    send_packet();

    // Longest skip, then the type option
    start_header(1'b1, 0);
    pkt_bytes.push_back(8'd12);
    pkt_bytes.push_back(8'd255);
    repeat (255) pkt_bytes.push_back(8'($urandom_range(0, 255)));
    pkt_bytes.push_back(OptMsgType);
    pkt_bytes.push_back(LenOne);
    pkt_bytes.push_back(8'h02);
    fit_length(520);
    send_packet();

    // Exactly the length limit, then one byte over it
    start_header(1'b1, 0);
    pkt_bytes.push_back(OptMsgType);
    pkt_bytes.push_back(LenOne);
    pkt_bytes.push_back(8'h06);
    fit_length(MaxLen);
    send_packet();
    start_header(1'b1, 0);
    pkt_bytes.push_back(OptMsgType);
    pkt_bytes.push_back(LenOne);
    pkt_bytes.push_back(8'h06);
    fit_length(MaxLen + 1);
    send_packet();

    // Past the counter's saturation point
    start_header(1'b1, 0);
    fill_random_options(2050);
    send_packet();

    drain_results();

    // --- random packets ---
    pkt_idx      = 0;
    random_bytes = 0;
    while (random_bytes < 800 || pkt_idx < 40) begin
      calm = (pkt_idx >= 8 && pkt_idx < 14);
      kind = $urandom_range(0, 99);
      if (kind < 70) begin
        start_header(1'b1, 0);
        fill_random_options($urandom_range(244, 330));
      end else if (kind < 80) begin
        start_header(1'b0, $urandom_range(0, 3));
        fill_random_options($urandom_range(244, 300));
      end else if (kind < 88) begin
        start_header(1'b1, 0);
        fill_random_options(250);
        fit_length($urandom_range(1, 243));
      end else if (kind < 93) begin
        start_header(1'b1, 0);
        fill_random_options($urandom_range(MaxLen - 24, MaxLen + 6));
      end else begin
        // Noise: random bytes throughout
        pkt_bytes.delete();
        fit_length($urandom_range(1, 400));
      end
      random_bytes += pkt_bytes.size();
      send_packet();
      if (pkt_idx == 20) drain_results();
      pkt_idx++;
    end
    calm = 1'b0;

    // Wait out the last results, then watch for strays before the verdict
    drain_results();
    repeat (TailCycles) @(negedge clk);
    if (fail_count == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule

// ----- dhcp_message_type_parser_top.f -----
sv/dmtp_pkg.sv
sv/dmtp_walk.sv
sv/dmtp_oreg.sv
sv/dhcp_message_type_parser_top.sv
verif/dhcp_message_type_checker.sv
verif/tb_dhcp_message_type_parser_top.sv
